@@ rtl/line_segment_rasterizer_macros.svh @@
// Assertion macros used by the port-level checker of the line rasterizer
`ifndef LINE_SEGMENT_RASTERIZER_MACROS_SVH
`define LINE_SEGMENT_RASTERIZER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define LSR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define LSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lsr_pkg.sv @@
// Shared types and constants of the line segment rasterizer
`default_nettype none

package lsr_pkg;

  // Default coordinate width and fixed color width
  localparam int COORD_BITS_DEF = 6;
  localparam int COLOR_W        = 24;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;  // capture endpoints and color
    logic init;  // order endpoints and set up the stepping registers
    logic step;  // emit the current pixel and advance
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic last;  // the current pixel is the final one of the segment
  } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/lsr_ctrl.sv @@
// Controller state machine of the line segment rasterizer
`default_nettype none

module lsr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  output lsr_pkg::dp_cmd_t       cmd,
  input  wire lsr_pkg::dp_stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SETUP = 3'b010,
    S_RUN   = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Sequence: capture, set up, then one pixel per cycle until the last
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_SETUP;
      end
      S_SETUP: begin
        state_nxt = S_RUN;
      end
      S_RUN: begin
        if (stat.last) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Drive datapath commands and the busy flag
  always_comb begin
    busy     = (state_r != S_IDLE);
    cmd.load = (state_r == S_IDLE) && start;
    cmd.init = (state_r == S_SETUP);
    cmd.step = (state_r == S_RUN);
  end

endmodule

`default_nettype wire

@@ rtl/lsr_dpath.sv @@
// Datapath of the line segment rasterizer: endpoint ordering and error stepping
`default_nettype none

module lsr_dpath #(
  parameter int COORD_BITS = lsr_pkg::COORD_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire lsr_pkg::dp_cmd_t           cmd,
  output lsr_pkg::dp_stat_t               stat,
  input  wire logic [COORD_BITS-1:0]      in_start_x,
  input  wire logic [COORD_BITS-1:0]      in_start_y,
  input  wire logic [COORD_BITS-1:0]      in_end_x,
  input  wire logic [COORD_BITS-1:0]      in_end_y,
  input  wire logic [lsr_pkg::COLOR_W-1:0] in_pixel_color,
  output logic                            out_valid,
  output logic [COORD_BITS-1:0]           out_pixel_x,
  output logic [COORD_BITS-1:0]           out_pixel_y,
  output logic [lsr_pkg::COLOR_W-1:0]     out_color,
  output logic                            out_last_pixel
);

  localparam int W = COORD_BITS;
  localparam int E = COORD_BITS + 3;  // error term, signed

  // Captured transaction
  logic [W-1:0]                ax_r, ay_r, bx_r, by_r;
  logic [lsr_pkg::COLOR_W-1:0] color_r;

  // Stepping state
  logic [W-1:0]        major_r, minor_r, cnt_r;
  logic signed [E-1:0] err_r, inc_r;
  logic [W:0]          mod_r;
  logic                steep_r;

  // Output registers
  logic                        out_valid_r;
  logic [W-1:0]                out_x_r, out_y_r;
  logic [lsr_pkg::COLOR_W-1:0] out_color_r;
  logic                        out_last_r;

  // Setup logic
  logic                swap;
  logic [W-1:0]        p0x, p0y, p1x, p1y;
  logic [W-1:0]        dx, ady;
  logic signed [W:0]   dy_s;
  logic                dy_neg, shallow;
  logic signed [E-1:0] inc2dx;
  logic [W-1:0]        major_init, minor_init, cnt_init;
  logic signed [E-1:0] err_init, inc_init;
  logic [W:0]          mod_init;

  // Step logic
  logic signed [E-1:0] sum, mod_s;
  logic signed [E-1:0] err_nxt;
  logic [W-1:0]        minor_nxt;

  // Order endpoints so x ascends, then y ascends on equal x
  always_comb begin
    swap   = (bx_r < ax_r) || ((bx_r == ax_r) && (by_r < ay_r));
    p0x    = swap ? bx_r : ax_r;
    p0y    = swap ? by_r : ay_r;
    p1x    = swap ? ax_r : bx_r;
    p1y    = swap ? ay_r : by_r;
    dx     = p1x - p0x;
    dy_s   = $signed({1'b0, p1y}) - $signed({1'b0, p0y});
    dy_neg = dy_s[W];
    ady    = dy_neg ? W'(-dy_s) : dy_s[W-1:0];
    shallow = (dx > ady);
    inc2dx = $signed({2'b00, dx, 1'b0});
    if (shallow) begin
      // x is the major axis; error counts dy against modulus dx (floor)
      major_init = p0x;
      minor_init = p0y;
      cnt_init   = dx;
      mod_init   = {1'b0, dx};
      inc_init   = {{2{dy_s[W]}}, dy_s};
      err_init   = '0;
    end else begin
      // y ascends; error counts 2dx against 2|dy|, offset by half (round up)
      major_init = dy_neg ? p1y : p0y;
      minor_init = dy_neg ? p1x : p0x;
      cnt_init   = ady;
      mod_init   = {ady, 1'b0};
      inc_init   = dy_neg ? -inc2dx : inc2dx;
      err_init   = $signed({3'b000, ady});
    end
  end

  // Advance the error term by one correction at most
  always_comb begin
    mod_s     = $signed({2'b00, mod_r});
    sum       = err_r + inc_r;
    err_nxt   = sum;
    minor_nxt = minor_r;
    if (sum >= mod_s) begin
      err_nxt   = sum - mod_s;
      minor_nxt = minor_r + 1'b1;
    end else if (sum < 0) begin
      err_nxt   = sum + mod_s;
      minor_nxt = minor_r - 1'b1;
    end
  end

  // Capture the transaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r    <= in_start_x;
      ay_r    <= in_start_y;
      bx_r    <= in_end_x;
      by_r    <= in_end_y;
      color_r <= in_pixel_color;
    end
  end

  // Load or advance the stepping registers
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      major_r <= major_init;
      minor_r <= minor_init;
      cnt_r   <= cnt_init;
      err_r   <= err_init;
      inc_r   <= inc_init;
      mod_r   <= mod_init;
      steep_r <= !shallow;
    end else if (cmd.step) begin
      major_r <= major_r + 1'b1;
      minor_r <= minor_nxt;
      cnt_r   <= cnt_r - 1'b1;
      err_r   <= err_nxt;
    end
  end

  // Register the emitted pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_x_r     <= steep_r ? minor_r : major_r;
      out_y_r     <= steep_r ? major_r : minor_r;
      out_color_r <= color_r;
      out_last_r  <= (cnt_r == '0);
    end
  end

  assign stat.last      = (cnt_r == '0);
  assign out_valid      = out_valid_r;
  assign out_pixel_x    = out_x_r;
  assign out_pixel_y    = out_y_r;
  assign out_color      = out_color_r;
  assign out_last_pixel = out_last_r;

endmodule

`default_nettype wire

@@ rtl/line_segment_rasterizer.sv @@
// Top level of the line segment rasterizer
//
// Usage:
//   Drive the two endpoints and the color on the in_ ports and raise start.
//   A transaction is taken at the rising edge where start is high and busy
//   is low. The segment is then emitted one pixel per cycle on the out_
//   ports; out_valid marks each pixel for exactly one cycle and
//   out_last_pixel marks the final one. The receiver cannot stall.
// Sequence:
//   After the accepting edge the controller passes through a setup state,
//   then steps the first pixel into the output register of the out_ ports.
//   A segment has N pixels, N = max(|dx|,|dy|) + 1; busy stays high through
//   setup and the stepping of all N pixels, and a new transaction is taken
//   only once busy has dropped again.
//   The rate is set by the stepping unit, which produces one pixel per cycle.
// Reset:
//   Synchronous, active low rst_n returns the controller to idle and clears
//   out_valid; a segment in progress is dropped.
`default_nettype none

module line_segment_rasterizer #(
  parameter int COORD_BITS = lsr_pkg::COORD_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [COORD_BITS-1:0]       in_start_x,
  input  wire logic [COORD_BITS-1:0]       in_start_y,
  input  wire logic [COORD_BITS-1:0]       in_end_x,
  input  wire logic [COORD_BITS-1:0]       in_end_y,
  input  wire logic [lsr_pkg::COLOR_W-1:0] in_pixel_color,
  output logic                             out_valid,
  output logic [COORD_BITS-1:0]            out_pixel_x,
  output logic [COORD_BITS-1:0]            out_pixel_y,
  output logic [lsr_pkg::COLOR_W-1:0]      out_color,
  output logic                             out_last_pixel
);

  lsr_pkg::dp_cmd_t  cmd;
  lsr_pkg::dp_stat_t stat;

  // Sequence the transaction
  lsr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  // Compute the pixels
  lsr_dpath #(
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .in_pixel_color (in_pixel_color),
    .out_valid      (out_valid),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_color      (out_color),
    .out_last_pixel (out_last_pixel)
  );

endmodule

`default_nettype wire

@@ rtl/lsr_checker.sv @@
// Port-level checker of the line segment rasterizer and its bind
`default_nettype none

`include "line_segment_rasterizer_macros.svh"

module lsr_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire logic out_last_pixel
);

  // An accepted transaction occupies the block in the next cycle
  `LSR_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")

  // No pixel shows in the cycle after an accept
  `LSR_ASSERT_NEXT(a_accept_quiet, start && !busy, !out_valid, "pixel right after accept")

  // Pixels of one segment come back to back until the last one
  `LSR_ASSERT_NEXT(a_burst, out_valid && !out_last_pixel, out_valid, "gap inside a segment")

  // The block stays busy while a segment still has pixels to come
  `LSR_ASSERT_SAME(a_busy_mid, out_valid && !out_last_pixel, busy, "idle inside a segment")

endmodule

bind line_segment_rasterizer lsr_checker u_lsr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_last_pixel (out_last_pixel)
);

`default_nettype wire

@@ test/line_segment_rasterizer_checker.sv @@
// Checker for the line segment rasterizer: predicts every pixel and compares it
`timescale 1ns / 1ps

module line_segment_rasterizer_checker #(
  parameter int CW = lsr_pkg::COORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic [CW-1:0]               in_start_x,
  input  logic [CW-1:0]               in_start_y,
  input  logic [CW-1:0]               in_end_x,
  input  logic [CW-1:0]               in_end_y,
  input  logic [lsr_pkg::COLOR_W-1:0] in_pixel_color,
  input  logic                        out_valid,
  input  logic [CW-1:0]               out_pixel_x,
  input  logic [CW-1:0]               out_pixel_y,
  input  logic [lsr_pkg::COLOR_W-1:0] out_color,
  input  logic                        out_last_pixel,
  output int                          fail_count,
  output int                          pending
);

  localparam int COLOR_W    = lsr_pkg::COLOR_W;
  localparam int REPORT_CAP = 40;

  typedef struct packed {
    logic [CW-1:0]      x;
    logic [CW-1:0]      y;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pixel_t;

  // pixels still owed by the block, oldest first
  pixel_t pixel_q[$];
  int     n_fail = 0;

  // integer division rounded toward minus infinity, den > 0
  function automatic int div_floor(int num, int den);
    int q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q -= 1;
    return q;
  endfunction

  function automatic void add_pixel(int x, int y, logic [COLOR_W-1:0] color);
    pixel_t p;
    p.x     = x[CW-1:0];
    p.y     = y[CW-1:0];
    p.color = color;
    p.last  = 1'b0;
    pixel_q.push_back(p);
  endfunction

  // queue every pixel of one segment in emission order
  function automatic void trace_segment(int ax, int ay, int bx, int by,
                                        logic [COLOR_W-1:0] color);
    int     dx, dy, i, num, den, lo, hi, t;
    pixel_t p;
    // order endpoints so x ascends, or y ascends on equal x
    if (bx < ax || (bx == ax && by < ay)) begin
      t = ax; ax = bx; bx = t;
      t = ay; ay = by; by = t;
    end
    dx = bx - ax;
    dy = by - ay;
    if (dx == 0 && dy == 0) begin
      add_pixel(ax, ay, color);
    end else if (dx == 0) begin
      for (i = ay; i <= by; i++) add_pixel(ax, i, color);
    end else if (dy == 0) begin
      for (i = ax; i <= bx; i++) add_pixel(i, ay, color);
    end else if (dx > (dy < 0 ? -dy : dy)) begin
      // shallow: step x, y rounded down
      for (i = ax; i <= bx; i++)
        add_pixel(i, div_floor(ay * dx + dy * (i - ax), dx), color);
    end else begin
      // steep: step y upward, x rounded half up
      lo = dy < 0 ? by : ay;
      hi = dy < 0 ? ay : by;
      for (i = lo; i <= hi; i++) begin
        num = ax * dy + (i - ay) * dx;
        den = dy;
        if (den < 0) begin
          num = -num;
          den = -den;
        end
        add_pixel(div_floor(2 * num + den, 2 * den), i, color);
      end
    end
    // mark the final pixel
    p = pixel_q.pop_back();
    p.last = 1'b1;
    pixel_q.push_back(p);
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      n_fail++;
      if (n_fail <= REPORT_CAP)
        $error("%s mismatch: expected %0h, got %0h", name, want, got);
    end
  endtask

  // compare outgoing pixels first, then queue the newly accepted transaction
  always @(posedge clk) begin : watch
    pixel_t want;
    if (!rst_n) begin
      pixel_q.delete();
    end else begin
      if (out_valid !== 1'b0) begin
        if (pixel_q.size() == 0) begin
          n_fail++;
          if (n_fail <= REPORT_CAP)
            $error("unexpected pixel x=%0d y=%0d", out_pixel_x, out_pixel_y);
        end else begin
          want = pixel_q.pop_front();
          compare_field("out_valid", 32'd1, 32'(out_valid));
          compare_field("out_pixel_x", 32'(want.x), 32'(out_pixel_x));
          compare_field("out_pixel_y", 32'(want.y), 32'(out_pixel_y));
          compare_field("out_color", 32'(want.color), 32'(out_color));
          compare_field("out_last_pixel", 32'(want.last), 32'(out_last_pixel));
        end
      end
      if (start === 1'b1 && busy === 1'b0)
        trace_segment(int'(in_start_x), int'(in_start_y), int'(in_end_x),
                      int'(in_end_y), in_pixel_color);
    end
    pending    <= pixel_q.size();
    fail_count <= n_fail;
  end

endmodule

@@ test/line_segment_rasterizer_tb.sv @@
// Testbench top for the line segment rasterizer: stimulus, timeout and verdict
`timescale 1ns / 1ps

module line_segment_rasterizer_tb;

  localparam int CW           = lsr_pkg::COORD_BITS_DEF;
  localparam int CMAX         = (1 << CW) - 1;
  localparam int COLOR_W      = lsr_pkg::COLOR_W;
  localparam int RANDOM_ITEMS = 360;

  logic               clk;
  logic               rst_n          = 1'b0;
  logic               start          = 1'b0;
  logic               busy;
  logic [CW-1:0]      in_start_x     = '0;
  logic [CW-1:0]      in_start_y     = '0;
  logic [CW-1:0]      in_end_x       = '0;
  logic [CW-1:0]      in_end_y       = '0;
  logic [COLOR_W-1:0] in_pixel_color = '0;
  logic               out_valid;
  logic [CW-1:0]      out_pixel_x;
  logic [CW-1:0]      out_pixel_y;
  logic [COLOR_W-1:0] out_color;
  logic               out_last_pixel;
  int                 fail_count;
  int                 pending;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  line_segment_rasterizer uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .in_pixel_color (in_pixel_color),
    .out_valid      (out_valid),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_color      (out_color),
    .out_last_pixel (out_last_pixel)
  );

  line_segment_rasterizer_checker #(.CW(CW)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .in_pixel_color (in_pixel_color),
    .out_valid      (out_valid),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_color      (out_color),
    .out_last_pixel (out_last_pixel),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // present one segment and hold it until the block takes the transaction
  task automatic draw(int sx, int sy, int ex, int ey, logic [COLOR_W-1:0] color);
    start          <= 1'b1;
    in_start_x     <= sx[CW-1:0];
    in_start_y     <= sy[CW-1:0];
    in_end_x       <= ex[CW-1:0];
    in_end_y       <= ey[CW-1:0];
    in_pixel_color <= color;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // drop start for a number of cycles, with junk on the data ports
  task automatic pause(int cycles);
    if (cycles > 0) begin
      start          <= 1'b0;
      in_start_x     <= CW'($urandom);
      in_start_y     <= CW'($urandom);
      in_end_x       <= CW'($urandom);
      in_end_y       <= CW'($urandom);
      in_pixel_color <= COLOR_W'($urandom);
      repeat (cycles) @(posedge clk);
    end
  endtask

  // hold off until every predicted pixel has come out
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic draw_random();
    int kind, sx, sy, ex, ey, d;
    kind = $urandom_range(0, 9);
    sx   = $urandom_range(0, CMAX);
    sy   = $urandom_range(0, CMAX);
    ex   = $urandom_range(0, CMAX);
    ey   = $urandom_range(0, CMAX);
    case (kind)
      4, 5, 6: begin
        // short segment around the first endpoint
        ex = sx ^ $urandom_range(0, 7);
        ey = sy ^ $urandom_range(0, 7);
      end
      7: ex = sx;
      8: ey = sy;
      9: begin
        if ($urandom_range(0, 1) == 0) begin
          ex = sx;
          ey = sy;
        end else begin
          // diagonal, either direction
          d  = $urandom_range(1, CMAX);
          sx = $urandom_range(0, CMAX - d);
          sy = $urandom_range(0, CMAX - d);
          ex = sx + d;
          ey = sy + d;
          if ($urandom_range(0, 1) == 0) begin
            ey = sy;
            sy = sy + d;
          end
        end
      end
      default: ;
    endcase
    draw(sx, sy, ex, ey, COLOR_W'($urandom));
  endtask

  initial begin
    int sent, burst, k;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    pause(2);

    // zero length at the corners, extreme colors
    draw(0, 0, 0, 0, 24'h000000);
    draw(CMAX, CMAX, CMAX, CMAX, 24'hFFFFFF);
    // vertical and horizontal, both directions, full span
    draw(5, 0, 5, CMAX, 24'hAAAAAA);
    draw(10, CMAX, 10, 0, 24'h555555);
    pause(3);
    draw(0, 31, CMAX, 31, 24'h123456);
    draw(CMAX, 0, 0, 0, 24'hFEDCBA);
    // shallow rising and falling, and given right to left
    draw(0, 0, CMAX, 20, 24'h0F0F0F);
    draw(0, CMAX, CMAX, 1, 24'hF0F0F0);
    draw(60, 5, 2, 30, 24'h00FF00);
    draw(0, 5, 7, 0, 24'h0000FF);
    pause(1);
    // steep rising and falling
    draw(3, 0, 20, CMAX, 24'hFF0000);
    draw(0, CMAX, 40, 0, 24'h800001);
    draw(50, 10, 10, 60, 24'h7FFFFE);
    // diagonals: equal spans go the steep way
    draw(0, 0, CMAX, CMAX, 24'hC3C3C3);
    draw(0, CMAX, CMAX, 0, 24'h3C3C3C);
    // half-pixel x rounds up, rising and falling
    draw(0, 0, 1, 2, 24'h010203);
    draw(0, 2, 1, 0, 24'hA5A5A5);
    draw(CMAX - 1, 10, CMAX, 13, 24'h5A5A5A);
    settle();

    // random bursts with short gaps, long gaps and full settles between them
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 12);
      for (k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        draw_random();
        sent++;
      end
      if ($urandom_range(0, 9) == 0)
        settle();
      else if ($urandom_range(0, 3) == 0)
        pause($urandom_range(20, 80));
      else
        pause($urandom_range(0, 4));
    end

    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
